>>> src/relative_span_unit_rounder_unit_defines.svh
// Assertion macros for the relative span rounder.
// Included by the top level; depends on nothing else.
`ifndef RELATIVE_SPAN_UNIT_ROUNDER_UNIT_DEFINES_SVH
`define RELATIVE_SPAN_UNIT_ROUNDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RSUR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsur: implication check failed");
`define RSUR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsur: next-cycle check failed");
`else
`define RSUR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSUR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/rsur_pkg.sv
// Types, constants, unit length and reciprocal tables for the relative span rounder.
// No dependencies.
package rsur_pkg;

    localparam int SECONDS_W  = 64;
    localparam int RAW_W      = SECONDS_W - 1;
    localparam int COUNT_W    = 39;
    localparam int LEN_W      = 25;
    localparam int NUM_W      = 57;
    localparam int RECIP_W    = 58;
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam int POW_W      = 4;
    localparam int RSH_W      = 7;
    localparam int SPLIT_W    = 32;
    localparam int N_HI_W     = NUM_W - SPLIT_W;
    localparam int R_HI_W     = RECIP_W - SPLIT_W;
    localparam int LL_W       = 2 * SPLIT_W;
    localparam int LH_W       = SPLIT_W + R_HI_W;
    localparam int HL_W       = N_HI_W + SPLIT_W;
    localparam int HH_W       = N_HI_W + R_HI_W;
    localparam int LO_SUM_W   = LH_W + SPLIT_W + 1;
    localparam int HI_SUM_W   = HH_W + SPLIT_W + 1;

    localparam logic [RAW_W-1:0] SOON_LIMIT = RAW_W'(45);
    localparam logic [LEN_W-1:0] MINUTE_LEN = LEN_W'(60);
    localparam logic [LEN_W-1:0] HOUR_LEN   = LEN_W'(3600);
    localparam logic [LEN_W-1:0] DAY_LEN    = LEN_W'(86400);
    localparam logic [LEN_W-1:0] MONTH_LEN  = LEN_W'(2592000);
    localparam logic [LEN_W-1:0] YEAR_LEN   = LEN_W'(31536000);

    // each unit length is split into a power of two and an odd part
    localparam int MINUTE_POW = 2;
    localparam int HOUR_POW   = 4;
    localparam int DAY_POW    = 7;
    localparam int MONTH_POW  = 8;
    localparam int YEAR_POW   = 7;

    localparam int MINUTE_ODD = int'(MINUTE_LEN >> MINUTE_POW);
    localparam int HOUR_ODD   = int'(HOUR_LEN >> HOUR_POW);
    localparam int DAY_ODD    = int'(DAY_LEN >> DAY_POW);
    localparam int MONTH_ODD  = int'(MONTH_LEN >> MONTH_POW);
    localparam int YEAR_ODD   = int'(YEAR_LEN >> YEAR_POW);

    localparam int MINUTE_RSH = NUM_W + $clog2(MINUTE_ODD);
    localparam int HOUR_RSH   = NUM_W + $clog2(HOUR_ODD);
    localparam int DAY_RSH    = NUM_W + $clog2(DAY_ODD);
    localparam int MONTH_RSH  = NUM_W + $clog2(MONTH_ODD);
    localparam int YEAR_RSH   = NUM_W + $clog2(YEAR_ODD);

    // ceil(2^rsh / odd), exact quotient for any numerator below 2^NUM_W
    localparam logic [127:0] RECIP_ONE = 128'd1;
    localparam logic [RECIP_W-1:0] MINUTE_RECIP = RECIP_W'(
        ((RECIP_ONE << MINUTE_RSH) + 128'(MINUTE_ODD - 1)) / 128'(MINUTE_ODD));
    localparam logic [RECIP_W-1:0] HOUR_RECIP = RECIP_W'(
        ((RECIP_ONE << HOUR_RSH) + 128'(HOUR_ODD - 1)) / 128'(HOUR_ODD));
    localparam logic [RECIP_W-1:0] DAY_RECIP = RECIP_W'(
        ((RECIP_ONE << DAY_RSH) + 128'(DAY_ODD - 1)) / 128'(DAY_ODD));
    localparam logic [RECIP_W-1:0] MONTH_RECIP = RECIP_W'(
        ((RECIP_ONE << MONTH_RSH) + 128'(MONTH_ODD - 1)) / 128'(MONTH_ODD));
    localparam logic [RECIP_W-1:0] YEAR_RECIP = RECIP_W'(
        ((RECIP_ONE << YEAR_RSH) + 128'(YEAR_ODD - 1)) / 128'(YEAR_ODD));

    typedef enum logic [2:0] {
        UNIT_SOON    = 3'd0,
        UNIT_MINUTES = 3'd1,
        UNIT_HOURS   = 3'd2,
        UNIT_DAYS    = 3'd3,
        UNIT_MONTHS  = 3'd4,
        UNIT_YEARS   = 3'd5
    } span_unit_t;

    function automatic logic [LEN_W-1:0] unit_len(input span_unit_t u);
        logic [LEN_W-1:0] len;
        unique case (u)
            UNIT_HOURS:  len = HOUR_LEN;
            UNIT_DAYS:   len = DAY_LEN;
            UNIT_MONTHS: len = MONTH_LEN;
            UNIT_YEARS:  len = YEAR_LEN;
            default:     len = MINUTE_LEN;
        endcase
        return len;
    endfunction

    function automatic logic [POW_W-1:0] unit_pow(input span_unit_t u);
        logic [POW_W-1:0] pow;
        unique case (u)
            UNIT_HOURS:  pow = POW_W'(HOUR_POW);
            UNIT_DAYS:   pow = POW_W'(DAY_POW);
            UNIT_MONTHS: pow = POW_W'(MONTH_POW);
            UNIT_YEARS:  pow = POW_W'(YEAR_POW);
            default:     pow = POW_W'(MINUTE_POW);
        endcase
        return pow;
    endfunction

    function automatic logic [RECIP_W-1:0] unit_recip(input span_unit_t u);
        logic [RECIP_W-1:0] recip;
        unique case (u)
            UNIT_HOURS:  recip = HOUR_RECIP;
            UNIT_DAYS:   recip = DAY_RECIP;
            UNIT_MONTHS: recip = MONTH_RECIP;
            UNIT_YEARS:  recip = YEAR_RECIP;
            default:     recip = MINUTE_RECIP;
        endcase
        return recip;
    endfunction

    function automatic logic [RSH_W-1:0] unit_rsh(input span_unit_t u);
        logic [RSH_W-1:0] rsh;
        unique case (u)
            UNIT_HOURS:  rsh = RSH_W'(HOUR_RSH);
            UNIT_DAYS:   rsh = RSH_W'(DAY_RSH);
            UNIT_MONTHS: rsh = RSH_W'(MONTH_RSH);
            UNIT_YEARS:  rsh = RSH_W'(YEAR_RSH);
            default:     rsh = RSH_W'(MINUTE_RSH);
        endcase
        return rsh;
    endfunction

endpackage

>>> src/relative_span_unit_rounder_unit.sv
// Five register stages; a result sits on the output register once its item has passed
// through the stages before it, and it leaves when out_stall is low.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Stages: unit select, bias and shift, partial products, partial sums, final sum.
// Reset clears all valid bits; payload registers are not reset.
// Depends on rsur_pkg and relative_span_unit_rounder_unit_defines.svh.
`include "relative_span_unit_rounder_unit_defines.svh"

module relative_span_unit_rounder_unit
    import rsur_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [63:0]  seconds_ahead,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          span_unit,
    output logic [COUNT_W-1:0]  span_count
);

    logic                   adv;
    logic                   sel_valid_reg;
    span_unit_t             sel_unit_reg;
    span_unit_t             sel_unit_next;
    logic [RAW_W-1:0]       sel_raw_reg;
    logic [RAW_W-1:0]       raw_in;
    logic [SECONDS_W-1:0]   bias_sum;
    logic [NUM_W-1:0]       num_next;

    logic                   num_valid_reg;
    span_unit_t             num_unit_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [RECIP_W-1:0]     recip;
    logic [LL_W-1:0]        pp_ll_next;
    logic [LH_W-1:0]        pp_lh_next;
    logic [HL_W-1:0]        pp_hl_next;
    logic [HH_W-1:0]        pp_hh_next;

    logic                   mul_valid_reg;
    span_unit_t             mul_unit_reg;
    logic [LL_W-1:0]        pp_ll_reg;
    logic [LH_W-1:0]        pp_lh_reg;
    logic [HL_W-1:0]        pp_hl_reg;
    logic [HH_W-1:0]        pp_hh_reg;
    logic [LO_SUM_W-1:0]    lo_sum_next;
    logic [HI_SUM_W-1:0]    hi_sum_next;

    logic                   sum_valid_reg;
    span_unit_t             sum_unit_reg;
    logic [LO_SUM_W-1:0]    lo_sum_reg;
    logic [HI_SUM_W-1:0]    hi_sum_reg;
    logic [PROD_W-1:0]      product;
    logic [COUNT_W-1:0]     count_next;

    logic                   out_valid_reg;
    span_unit_t             out_unit_reg;
    logic [COUNT_W-1:0]     out_count_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // unit select on raw seconds
    assign raw_in = seconds_ahead[RAW_W-1:0];

    always_comb
    begin
        if (seconds_ahead[SECONDS_W-1] || raw_in < SOON_LIMIT)
            sel_unit_next = UNIT_SOON;
        else if (raw_in < RAW_W'(HOUR_LEN))
            sel_unit_next = UNIT_MINUTES;
        else if (raw_in < RAW_W'(DAY_LEN))
            sel_unit_next = UNIT_HOURS;
        else if (raw_in < RAW_W'(MONTH_LEN))
            sel_unit_next = UNIT_DAYS;
        else if (raw_in < RAW_W'(YEAR_LEN))
            sel_unit_next = UNIT_MONTHS;
        else
            sel_unit_next = UNIT_YEARS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else if (adv)
            sel_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_unit_reg <= sel_unit_next;
            sel_raw_reg  <= raw_in;
        end
    end

    // add half a unit so truncating division rounds half up, drop the power of two
    always_comb
    begin
        if (sel_unit_reg == UNIT_SOON)
            bias_sum = '0;
        else
            bias_sum = SECONDS_W'(sel_raw_reg)
                     + SECONDS_W'(unit_len(sel_unit_reg) >> 1);
        num_next = NUM_W'(bias_sum >> unit_pow(sel_unit_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_valid_reg <= 1'b0;
        else if (adv)
            num_valid_reg <= sel_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_unit_reg <= sel_unit_reg;
            num_reg      <= num_next;
        end
    end

    // divide by the odd part with a reciprocal multiply, split into 32-bit pieces
    always_comb
    begin
        recip      = unit_recip(num_unit_reg);
        pp_ll_next = LL_W'(num_reg[SPLIT_W-1:0]) * LL_W'(recip[SPLIT_W-1:0]);
        pp_lh_next = LH_W'(num_reg[SPLIT_W-1:0]) * LH_W'(recip[RECIP_W-1:SPLIT_W]);
        pp_hl_next = HL_W'(num_reg[NUM_W-1:SPLIT_W]) * HL_W'(recip[SPLIT_W-1:0]);
        pp_hh_next = HH_W'(num_reg[NUM_W-1:SPLIT_W]) * HH_W'(recip[RECIP_W-1:SPLIT_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (adv)
            mul_valid_reg <= num_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_unit_reg <= num_unit_reg;
            pp_ll_reg    <= pp_ll_next;
            pp_lh_reg    <= pp_lh_next;
            pp_hl_reg    <= pp_hl_next;
            pp_hh_reg    <= pp_hh_next;
        end
    end

    always_comb
    begin
        lo_sum_next = LO_SUM_W'(pp_ll_reg) + (LO_SUM_W'(pp_lh_reg) << SPLIT_W);
        hi_sum_next = (HI_SUM_W'(pp_hh_reg) << SPLIT_W) + HI_SUM_W'(pp_hl_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else if (adv)
            sum_valid_reg <= mul_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_unit_reg <= mul_unit_reg;
            lo_sum_reg   <= lo_sum_next;
            hi_sum_reg   <= hi_sum_next;
        end
    end

    always_comb
    begin
        product    = PROD_W'(lo_sum_reg) + (PROD_W'(hi_sum_reg) << SPLIT_W);
        count_next = COUNT_W'(product >> unit_rsh(sum_unit_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sum_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_unit_reg  <= sum_unit_reg;
            out_count_reg <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_unit  = out_unit_reg;
    assign span_count = out_count_reg;

    `RSUR_ASSERT_IMP(a_soon_zero, clk, rst_n, out_valid && span_unit == UNIT_SOON,
                     span_count == '0)
    `RSUR_ASSERT_IMP(a_min_range, clk, rst_n, out_valid && span_unit == UNIT_MINUTES,
                     span_count >= COUNT_W'(1) && span_count <= COUNT_W'(60))
    `RSUR_ASSERT_IMP(a_hour_range, clk, rst_n, out_valid && span_unit == UNIT_HOURS,
                     span_count >= COUNT_W'(1) && span_count <= COUNT_W'(24))
    `RSUR_ASSERT_NXT(a_hold_stall, clk, rst_n, out_valid && out_stall,
                     in_stall == (out_valid && out_stall))

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for relative_span_unit_rounder_unit: a falling-edge driver fed
// from a queue of pending seconds values, a rising-edge monitor comparing each result.
// Depends on rsur_pkg and the relative_span_unit_rounder_unit RTL.
module tb_top;
    import rsur_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        span_unit_t         unit;
        logic [COUNT_W-1:0] count;
    } span_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [63:0]        seconds_ahead;
    logic                      out_valid;
    logic                      out_stall;
    logic [2:0]                span_unit;
    logic [COUNT_W-1:0]        span_count;

    logic [63:0]               pending_q [$];
    span_result_t              span_due_q [$];
    span_result_t              span_want;
    logic                      in_fire;
    logic                      quiet;
    int                        cycle_n;
    int                        gap_left;
    int                        stall_left;
    int                        sent_n;
    int                        accepted_n;
    int                        drain_a;
    int                        drain_b;
    int                        error_n;
    int                        unit_seen [6];

    relative_span_unit_rounder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .seconds_ahead (seconds_ahead),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .span_unit     (span_unit),
        .span_count    (span_count)
    );

    function automatic span_result_t predict_span(input logic signed [63:0] secs);
        span_result_t res;
        logic [63:0]  mag;
        logic [63:0]  len;
        logic [63:0]  whole;
        logic [63:0]  rest;
        mag = secs;
        if (mag[63] || mag[62:0] < SOON_LIMIT)
        begin
            res.unit  = UNIT_SOON;
            res.count = '0;
        end
        else
        begin
            if (mag < 64'(HOUR_LEN))
            begin
                res.unit = UNIT_MINUTES;
                len      = 64'(MINUTE_LEN);
            end
            else if (mag < 64'(DAY_LEN))
            begin
                res.unit = UNIT_HOURS;
                len      = 64'(HOUR_LEN);
            end
            else if (mag < 64'(MONTH_LEN))
            begin
                res.unit = UNIT_DAYS;
                len      = 64'(DAY_LEN);
            end
            else if (mag < 64'(YEAR_LEN))
            begin
                res.unit = UNIT_MONTHS;
                len      = 64'(MONTH_LEN);
            end
            else
            begin
                res.unit = UNIT_YEARS;
                len      = 64'(YEAR_LEN);
            end
            whole = mag / len;
            rest  = mag % len;
            if (rest * 64'd2 >= len)
                whole = whole + 64'd1;
            res.count = whole[COUNT_W-1:0];
        end
        return res;
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] unit_span(input int idx);
        case (idx)
            0:       return 64'(MINUTE_LEN);
            1:       return 64'(HOUR_LEN);
            2:       return 64'(DAY_LEN);
            3:       return 64'(MONTH_LEN);
            default: return 64'(YEAR_LEN);
        endcase
    endfunction

    function automatic logic [63:0] rand_seconds();
        logic [63:0] v;
        logic [63:0] len;
        logic [63:0] lo;
        logic [63:0] hi;
        int          idx;
        idx = $urandom_range(0, 4);
        len = unit_span(idx);
        case ($urandom_range(0, 9))
            0, 1: v = {$urandom, $urandom};
            2:    v = {1'b1, 31'($urandom), 32'($urandom)};
            3:    v = 64'($urandom_range(0, 200));
            4:
            begin
                lo = (idx == 0) ? 64'(SOON_LIMIT) : len;
                v  = lo + 64'($urandom_range(0, 6)) - 64'd3;
            end
            5:    v = 64'($urandom_range(0, 1000)) * len + len / 64'd2
                      + 64'($urandom_range(0, 2)) - 64'd1;
            6:    v = 64'(YEAR_LEN) + ({$urandom, $urandom} >> $urandom_range(20, 63));
            7:
            begin
                lo = (idx == 0) ? 64'(SOON_LIMIT) : len;
                hi = (idx == 4) ? 64'd40000000000 : unit_span(idx + 1);
                v  = lo + 64'($urandom) % (hi - lo);
            end
            8:    v = {1'b0, 31'($urandom), 32'($urandom)};
            default: v = {$urandom, $urandom} >> $urandom_range(1, 63);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_n++;
    endtask

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_q.size() == 0 ||
                 ((sent_n == drain_a || sent_n == drain_b) && span_due_q.size() != 0))
            in_valid <= 1'b0;
        else
        begin
            in_valid      <= 1'b1;
            seconds_ahead <= pending_q.pop_front();
            sent_n        <= sent_n + 1;
            gap_left      <= quiet ? 0 : pick_idle();
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= quiet ? 0 : pick_idle();
        end
    end

    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        cycle_n <= cycle_n + 1;
        quiet   <= (cycle_n % 512) < 128;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (span_due_q.size() == 0)
                    report_mismatch($sformatf("unexpected result unit %0d count %0d",
                                              span_unit, span_count));
                else
                begin
                    span_want = span_due_q.pop_front();
                    if (span_unit !== span_want.unit)
                        report_mismatch($sformatf("span_unit got %0d want %0d",
                                                  span_unit, span_want.unit));
                    if (span_count !== span_want.count)
                        report_mismatch($sformatf("span_count got %0d want %0d (unit %0d)",
                                                  span_count, span_want.count,
                                                  span_want.unit));
                    unit_seen[span_want.unit]++;
                end
            end
            if (in_valid && !in_stall)
            begin
                span_due_q.push_back(predict_span(seconds_ahead));
                accepted_n++;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        logic [63:0] directed [$];
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        seconds_ahead = '0;
        in_fire       = 1'b0;
        quiet         = 1'b1;
        cycle_n       = 0;
        gap_left      = 0;
        stall_left    = 0;
        sent_n        = 0;
        accepted_n    = 0;
        error_n       = 0;
        foreach (unit_seen[i])
            unit_seen[i] = 0;

        directed = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'd44, 64'd45, 64'd89, 64'd90,
                     64'd3599, 64'd3600, 64'd5399, 64'd5400, 64'd86399, 64'd86400,
                     64'd129600, 64'd2591999, 64'd2592000, 64'd3888000, 64'd31535999,
                     64'd31536000, 64'd47304000, 64'd47303999, 64'hFFFF_FFFF_FFFF_FFD3};
        foreach (directed[i])
            pending_q.push_back(directed[i]);
        drain_a = directed.size();
        drain_b = drain_a + 300;
        repeat (650)
            pending_q.push_back(rand_seconds());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid || span_due_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("covered %0d items; results soon %0d, minutes %0d, hours %0d, days %0d,",
                 accepted_n, unit_seen[0], unit_seen[1], unit_seen[2], unit_seen[3]);
        $display("months %0d, years %0d; %0d mismatches", unit_seen[4], unit_seen[5],
                 error_n);
        if (error_n == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
